// ===== sv/bezier_outline_flattener_macros.svh =====
// Assertion helpers for the flattener RTL.
`ifndef BEZIER_OUTLINE_FLATTENER_MACROS_SVH
`define BEZIER_OUTLINE_FLATTENER_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define BOF_ASSERT_NOW(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define BOF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BOF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bof_pkg.sv =====
package bof_pkg;

    localparam int STEPS   = 15;
    localparam int COORD_W = 16;
    localparam int SCALE_W = 24;
    localparam int PT_W    = 32;
    localparam int CMD_W   = 2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

    localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LINE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUAD  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CUBIC = 2'd3;

    // Bernstein weights are bounded by STEPS^3, the cubic denominator
    localparam int W_W       = $clog2(STEPS * STEPS * STEPS + 1);
    localparam int I_W       = $clog2(STEPS + 1);
    localparam int PROD_W    = W_W + 1 + PT_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int DIV_CYC   = (SUM_W + 7) / 8;
    localparam int MAG_W     = DIV_CYC * 8;
    localparam int DCNT_W    = $clog2(DIV_CYC);

    localparam logic [W_W-1:0] DEN_QUAD  = W_W'(STEPS * STEPS);
    localparam logic [W_W-1:0] DEN_CUBIC = W_W'(STEPS * STEPS * STEPS);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic signed [PT_W-1:0] c1x;
        logic signed [PT_W-1:0] c1y;
        logic signed [PT_W-1:0] c2x;
        logic signed [PT_W-1:0] c2y;
        logic signed [PT_W-1:0] tx;
        logic signed [PT_W-1:0] ty;
    } t_item;

    typedef logic [3:0][W_W-1:0] t_wts;

    // Weights for pen, ctrl1, ctrl2, end point at mu = idx/STEPS.
    // Quadratic leaves the ctrl2 weight at zero.
    function automatic t_wts bern_wts(input logic cubic, input logic [I_W-1:0] idx);
        int   a;
        int   b;
        t_wts w;
        a = STEPS - int'(idx);
        b = int'(idx);
        if (cubic) begin
            w[0] = W_W'(a * a * a);
            w[1] = W_W'(3 * b * a * a);
            w[2] = W_W'(3 * b * b * a);
            w[3] = W_W'(b * b * b);
        end else begin
            w[0] = W_W'(a * a);
            w[1] = W_W'(2 * a * b);
            w[2] = '0;
            w[3] = W_W'(b * b);
        end
        return w;
    endfunction

endpackage

// ===== sv/bezier_outline_flattener.sv =====
// Glyph outline flattener.
// Input stream (s side): one outline command per request; tuser carries the
// command (move, line, quadratic, cubic), tdata the control and end points.
// Output stream (m side): one vertex per request in signed Q16.16; tuser[0]
// flags a vertex that opens a contour, tlast marks the final vertex of a
// command. A move or line yields one vertex, a curve fifteen.
// i_cfg_we/i_cfg_wdata load the unsigned Q8.16 scale factor; write it only
// while the block is idle.
// Flow: points are scaled in the input stage, pass a two-entry queue, then
// the sequencer runs. Move/line: the sequencer goes from idle straight to
// the output load. Curves: each vertex passes weight multiply, sum,
// magnitude, 8-bit-per-cycle division by the Bernstein denominator,
// rounding and output load. The sequencer takes a new command only when
// idle, once the last vertex of the one before it is loaded.
// Reset clears the pen to the origin, the scale to 1.0, and empties the
// queue and output register. A stalled receiver holds the output register;
// the sequencer and then the queue and input stage back up behind it.
`include "bezier_outline_flattener_macros.svh"

module bezier_outline_flattener (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bof_pkg::SCALE_W-1:0]       i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, to_x, to_y (16 bits each)
    input  logic [6*bof_pkg::COORD_W-1:0]     i_s_tdata,
    // cmd
    input  logic [bof_pkg::CMD_W-1:0]         i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // point_x, point_y (32 bits each)
    output logic [2*bof_pkg::PT_W-1:0]        o_m_tdata,
    // contour_start
    output logic [0:0]                        o_m_tuser,
    output logic                              o_m_tlast
);

    logic                            f_valid;
    logic                            q_ready;
    bof_pkg::t_item                  f_item;
    logic                            b_valid;
    logic                            b_ready;
    bof_pkg::t_item                  b_item;
    logic signed [bof_pkg::PT_W-1:0] pt_x;
    logic signed [bof_pkg::PT_W-1:0] pt_y;
    logic                            pt_start;

    bof_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_cmd       (i_s_tuser),
        .i_coords    (i_s_tdata),
        .o_valid     (f_valid),
        .o_item      (f_item),
        .i_ready     (q_ready)
    );

    bof_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (q_ready),
        .i_push_item  (f_item),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_item   (b_item)
    );

    bof_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (b_valid),
        .o_pop_ready (b_ready),
        .i_pop_item  (b_item),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_x         (pt_x),
        .o_y         (pt_y),
        .o_start     (pt_start),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {pt_y, pt_x};
    assign o_m_tuser = pt_start;

    // a contour opener is always the only vertex of its command
    `BOF_ASSERT_NOW(a_start_is_last, !(o_m_tvalid && o_m_tuser[0]) || o_m_tlast, "start not last")
    // a scaled command waiting on a full queue is neither lost nor altered
    `BOF_ASSERT_NEXT(a_front_hold, f_valid && !q_ready, f_valid && $stable(f_item), "front dropped")
    // nothing leaves in the first cycle after reset
    `BOF_ASSERT_IMPL(a_rst_quiet, !$past(i_rst_n), !o_m_tvalid, "valid after reset")

endmodule

// ===== sv/bof_front.sv =====
module bof_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bof_pkg::SCALE_W-1:0]       i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [bof_pkg::CMD_W-1:0]         i_cmd,
    input  logic [6*bof_pkg::COORD_W-1:0]     i_coords,
    output logic                              o_valid,
    output bof_pkg::t_item                    o_item,
    input  logic                              i_ready
);

    localparam int P_W = bof_pkg::COORD_W + bof_pkg::SCALE_W + 1;

    logic                         r_valid;
    logic [bof_pkg::SCALE_W-1:0]  r_scale;
    bof_pkg::t_item               r_item;
    bof_pkg::t_item               n_item;

    // font units times Q8.16 scale, clamped to signed Q16.16
    function automatic logic signed [bof_pkg::PT_W-1:0] scale_sat(
        input logic signed [bof_pkg::COORD_W-1:0] c,
        input logic [bof_pkg::SCALE_W-1:0]        s
    );
        logic signed [P_W-1:0]               p;
        logic [P_W-bof_pkg::PT_W:0]           hi;
        logic signed [bof_pkg::PT_W-1:0]     res;
        p  = c * $signed({1'b0, s});
        hi = p[P_W-1:bof_pkg::PT_W-1];
        if ((&hi) || !(|hi)) begin
            res = p[bof_pkg::PT_W-1:0];
        end else if (p[P_W-1]) begin
            res = {1'b1, {(bof_pkg::PT_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(bof_pkg::PT_W-1){1'b1}}};
        end
        return res;
    endfunction

    always_comb begin
        n_item.cmd = i_cmd;
        n_item.c1x = scale_sat(i_coords[0*bof_pkg::COORD_W +: bof_pkg::COORD_W], r_scale);
        n_item.c1y = scale_sat(i_coords[1*bof_pkg::COORD_W +: bof_pkg::COORD_W], r_scale);
        n_item.c2x = scale_sat(i_coords[2*bof_pkg::COORD_W +: bof_pkg::COORD_W], r_scale);
        n_item.c2y = scale_sat(i_coords[3*bof_pkg::COORD_W +: bof_pkg::COORD_W], r_scale);
        n_item.tx  = scale_sat(i_coords[4*bof_pkg::COORD_W +: bof_pkg::COORD_W], r_scale);
        n_item.ty  = scale_sat(i_coords[5*bof_pkg::COORD_W +: bof_pkg::COORD_W], r_scale);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_scale <= bof_pkg::SCALE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== sv/bof_queue.sv =====
module bof_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  bof_pkg::t_item i_push_item,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output bof_pkg::t_item o_pop_item
);

    bof_pkg::t_item              r_mem [bof_pkg::Q_DEPTH];
    logic [bof_pkg::Q_PTR_W-1:0] r_wr;
    logic [bof_pkg::Q_PTR_W-1:0] r_rd;
    logic [bof_pkg::Q_CNT_W-1:0] r_cnt;
    logic                        push;
    logic                        pop;

    function automatic logic [bof_pkg::Q_PTR_W-1:0] ptr_inc(
        input logic [bof_pkg::Q_PTR_W-1:0] p
    );
        return (p == bof_pkg::Q_PTR_W'(bof_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_push_ready = (r_cnt != bof_pkg::Q_CNT_W'(bof_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

// ===== sv/bof_back.sv =====
module bof_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_pop_valid,
    output logic                            o_pop_ready,
    input  bof_pkg::t_item                  i_pop_item,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [bof_pkg::PT_W-1:0] o_x,
    output logic signed [bof_pkg::PT_W-1:0] o_y,
    output logic                            o_start,
    output logic                            o_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_ABS  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_RND  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    localparam int PT_W  = bof_pkg::PT_W;
    localparam int W_W   = bof_pkg::W_W;

    logic [2:0]                    r_state;
    bof_pkg::t_item                r_item;
    logic signed [PT_W-1:0]        r_pen_x;
    logic signed [PT_W-1:0]        r_pen_y;
    logic [bof_pkg::I_W-1:0]       r_idx;
    logic                          r_single;
    logic signed [bof_pkg::PROD_W-1:0] r_px [4];
    logic signed [bof_pkg::PROD_W-1:0] r_py [4];
    logic signed [bof_pkg::SUM_W-1:0]  r_sum_x;
    logic signed [bof_pkg::SUM_W-1:0]  r_sum_y;
    logic                          r_neg_x;
    logic                          r_neg_y;
    logic [bof_pkg::MAG_W-1:0]     r_dvd_x;
    logic [bof_pkg::MAG_W-1:0]     r_dvd_y;
    logic [PT_W-1:0]               r_quo_x;
    logic [PT_W-1:0]               r_quo_y;
    logic [W_W-1:0]                r_rem_x;
    logic [W_W-1:0]                r_rem_y;
    logic [bof_pkg::DCNT_W-1:0]    r_dcnt;
    logic [PT_W-1:0]               r_res_x;
    logic [PT_W-1:0]               r_res_y;
    logic                          r_ovalid;
    logic [PT_W-1:0]               r_ox;
    logic [PT_W-1:0]               r_oy;
    logic                          r_ostart;
    logic                          r_olast;

    bof_pkg::t_wts                 wts;
    logic signed [PT_W-1:0]        pts_x [4];
    logic signed [PT_W-1:0]        pts_y [4];
    logic [W_W-1:0]                den;
    logic [bof_pkg::SUM_W-1:0]     n_mag_x;
    logic [bof_pkg::SUM_W-1:0]     n_mag_y;
    logic [W_W+7:0]                n_step_x;
    logic [W_W+7:0]                n_step_y;
    logic [PT_W-1:0]               n_res_x;
    logic [PT_W-1:0]               n_res_y;
    logic                          out_free;
    logic                          emit_last;

    // Eight restoring-division steps; remainder stays below den.
    function automatic logic [W_W+7:0] div8(
        input logic [W_W-1:0] rem,
        input logic [7:0]     bits,
        input logic [W_W-1:0] d
    );
        logic [W_W-1:0] r;
        logic [W_W:0]   t;
        logic [7:0]     q;
        r = rem;
        q = '0;
        for (int j = 7; j >= 0; j--) begin
            t = {r, bits[j]};
            if (t >= {1'b0, d}) begin
                t    = t - {1'b0, d};
                q[j] = 1'b1;
            end
            r = t[W_W-1:0];
        end
        return {r, q};
    endfunction

    // round half away from zero on the magnitude, then restore sign
    function automatic logic [PT_W-1:0] round_sign(
        input logic [PT_W-1:0] quo,
        input logic [W_W-1:0]  rem,
        input logic            neg,
        input logic [W_W-1:0]  d
    );
        logic rup;
        rup = ({rem, 1'b0} >= {1'b0, d});
        return neg ? (~quo + PT_W'(!rup)) : (quo + PT_W'(rup));
    endfunction

    always_comb begin
        wts      = bof_pkg::bern_wts(r_item.cmd == bof_pkg::CMD_CUBIC, r_idx);
        pts_x[0] = r_pen_x;
        pts_x[1] = r_item.c1x;
        pts_x[2] = r_item.c2x;
        pts_x[3] = r_item.tx;
        pts_y[0] = r_pen_y;
        pts_y[1] = r_item.c1y;
        pts_y[2] = r_item.c2y;
        pts_y[3] = r_item.ty;
        den      = (r_item.cmd == bof_pkg::CMD_CUBIC) ? bof_pkg::DEN_CUBIC : bof_pkg::DEN_QUAD;
        n_mag_x  = r_sum_x[bof_pkg::SUM_W-1] ? (~r_sum_x + 1'b1) : r_sum_x;
        n_mag_y  = r_sum_y[bof_pkg::SUM_W-1] ? (~r_sum_y + 1'b1) : r_sum_y;
        n_step_x = div8(r_rem_x, r_dvd_x[bof_pkg::MAG_W-1 -: 8], den);
        n_step_y = div8(r_rem_y, r_dvd_y[bof_pkg::MAG_W-1 -: 8], den);
        n_res_x  = round_sign(r_quo_x, r_rem_x, r_neg_x, den);
        n_res_y  = round_sign(r_quo_y, r_rem_y, r_neg_y, den);
    end

    assign out_free    = !r_ovalid || i_ready;
    assign emit_last   = r_single || (r_idx == bof_pkg::I_W'(bof_pkg::STEPS));
    assign o_pop_ready = (r_state == ST_IDLE);
    assign o_valid     = r_ovalid;
    assign o_x         = r_ox;
    assign o_y         = r_oy;
    assign o_start     = r_ostart;
    assign o_last      = r_olast;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_pen_x  <= '0;
            r_pen_y  <= '0;
        end else begin
            // in ST_EMIT a taken vertex is replaced by the next one below
            if (r_ovalid && i_ready && r_state != ST_EMIT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_pop_valid) begin
                        if (i_pop_item.cmd == bof_pkg::CMD_MOVE ||
                            i_pop_item.cmd == bof_pkg::CMD_LINE) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: r_state <= ST_SUM;
                ST_SUM: r_state <= ST_ABS;
                ST_ABS: r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_dcnt == bof_pkg::DCNT_W'(bof_pkg::DIV_CYC - 1)) begin
                        r_state <= ST_RND;
                    end
                end
                ST_RND: r_state <= ST_EMIT;
                ST_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        if (emit_last) begin
                            r_pen_x <= r_item.tx;
                            r_pen_y <= r_item.ty;
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_item   <= i_pop_item;
                r_idx    <= bof_pkg::I_W'(1);
                r_single <= (i_pop_item.cmd == bof_pkg::CMD_MOVE ||
                             i_pop_item.cmd == bof_pkg::CMD_LINE);
                r_res_x  <= i_pop_item.tx;
                r_res_y  <= i_pop_item.ty;
            end
            ST_MUL: begin
                for (int k = 0; k < 4; k++) begin
                    r_px[k] <= $signed({1'b0, wts[k]}) * pts_x[k];
                    r_py[k] <= $signed({1'b0, wts[k]}) * pts_y[k];
                end
            end
            ST_SUM: begin
                r_sum_x <= r_px[0] + r_px[1] + r_px[2] + r_px[3];
                r_sum_y <= r_py[0] + r_py[1] + r_py[2] + r_py[3];
            end
            ST_ABS: begin
                r_neg_x <= r_sum_x[bof_pkg::SUM_W-1];
                r_neg_y <= r_sum_y[bof_pkg::SUM_W-1];
                r_dvd_x <= bof_pkg::MAG_W'(n_mag_x);
                r_dvd_y <= bof_pkg::MAG_W'(n_mag_y);
                r_rem_x <= '0;
                r_rem_y <= '0;
                r_quo_x <= '0;
                r_quo_y <= '0;
                r_dcnt  <= '0;
            end
            ST_DIV: begin
                r_rem_x <= n_step_x[W_W+7:8];
                r_rem_y <= n_step_y[W_W+7:8];
                r_quo_x <= {r_quo_x[PT_W-9:0], n_step_x[7:0]};
                r_quo_y <= {r_quo_y[PT_W-9:0], n_step_y[7:0]};
                r_dvd_x <= r_dvd_x << 8;
                r_dvd_y <= r_dvd_y << 8;
                r_dcnt  <= r_dcnt + 1'b1;
            end
            ST_RND: begin
                r_res_x <= n_res_x;
                r_res_y <= n_res_y;
            end
            ST_EMIT: begin
                if (out_free) begin
                    r_ox     <= r_res_x;
                    r_oy     <= r_res_y;
                    r_olast  <= emit_last;
                    r_ostart <= r_single && (r_item.cmd == bof_pkg::CMD_MOVE);
                    r_idx    <= r_idx + 1'b1;
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

endmodule

// ===== test/bezier_outline_flattener_check.sv =====
module bezier_outline_flattener_check
    import bof_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [SCALE_W-1:0]        i_cfg_wdata,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [6*COORD_W-1:0]      i_s_tdata,
    input  logic [CMD_W-1:0]          i_s_tuser,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [2*PT_W-1:0]         i_m_tdata,
    input  logic [0:0]                i_m_tuser,
    input  logic                      i_m_tlast,
    output int                        o_errors,
    output int                        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint PT_MAX = 64'sd2147483647;
    localparam longint PT_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic                   contour_start;
        logic                   last_of_cmd;
    } vertex_t;

    vertex_t                expected_vertices[$];
    logic [SCALE_W-1:0]     scale_reg;
    logic signed [PT_W-1:0] cur_x;
    logic signed [PT_W-1:0] cur_y;
    int                     mismatches = 0;

    function automatic logic signed [PT_W-1:0] clamp32(input longint v);
        if (v > PT_MAX) return PT_W'(PT_MAX);
        if (v < PT_MIN) return PT_W'(PT_MIN);
        return PT_W'(v);
    endfunction

    // font units times unsigned Q8.16 gives Q16.16
    function automatic logic signed [PT_W-1:0] to_q16(input logic [COORD_W-1:0] raw);
        longint prod;
        prod = longint'($signed(raw)) * longint'(scale_reg);
        return clamp32(prod);
    endfunction

    // nearest, ties away from zero
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] expv,
                                        input logic signed [63:0] got);
        if (got !== expv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, got);
            mismatches++;
        end
    endfunction

    function automatic void predict_vertices(input logic [CMD_W-1:0] cmd,
                                             input logic [6*COORD_W-1:0] pts);
        logic signed [PT_W-1:0] p[6];   // c1x c1y c2x c2y tx ty
        longint                 w[4];
        longint                 a;
        longint                 b;
        longint                 den;
        longint                 sx;
        longint                 sy;
        vertex_t                v;
        for (int k = 0; k < 6; k++) p[k] = to_q16(pts[k*COORD_W +: COORD_W]);
        if (cmd == CMD_MOVE || cmd == CMD_LINE) begin
            v.x             = p[4];
            v.y             = p[5];
            v.contour_start = (cmd == CMD_MOVE);
            v.last_of_cmd   = 1'b1;
            expected_vertices = {expected_vertices, v};
        end else begin
            for (int i = 1; i <= STEPS; i++) begin
                a = STEPS - i;
                b = i;
                if (cmd == CMD_QUAD) begin
                    w[0] = a * a;
                    w[1] = 2 * a * b;
                    w[2] = 0;
                    w[3] = b * b;
                    den  = STEPS * STEPS;
                end else begin
                    w[0] = a * a * a;
                    w[1] = 3 * b * a * a;
                    w[2] = 3 * b * b * a;
                    w[3] = b * b * b;
                    den  = STEPS * STEPS * STEPS;
                end
                sx = w[0] * cur_x + w[1] * p[0] + w[2] * p[2] + w[3] * p[4];
                sy = w[0] * cur_y + w[1] * p[1] + w[2] * p[3] + w[3] * p[5];
                v.x             = clamp32(round_div(sx, den));
                v.y             = clamp32(round_div(sy, den));
                v.contour_start = 1'b0;
                v.last_of_cmd   = (i == STEPS);
                expected_vertices = {expected_vertices, v};
            end
        end
        cur_x = p[4];
        cur_y = p[5];
    endfunction

    always @(posedge i_clk) begin
        vertex_t want;
        if (!i_rst_n) begin
            scale_reg = SCALE_RESET;
            cur_x     = '0;
            cur_y     = '0;
            expected_vertices.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_vertices.size() == 0) begin
                    $error("vertex with nothing expected: point_x %0d point_y %0d",
                           $signed(i_m_tdata[PT_W-1:0]), $signed(i_m_tdata[2*PT_W-1:PT_W]));
                    mismatches++;
                end else begin
                    want = expected_vertices.pop_front();
                    check_field("point_x", want.x, $signed(i_m_tdata[PT_W-1:0]));
                    check_field("point_y", want.y, $signed(i_m_tdata[2*PT_W-1:PT_W]));
                    check_field("contour_start", want.contour_start, i_m_tuser[0]);
                    check_field("last", want.last_of_cmd, i_m_tlast);
                end
            end
            if (i_cfg_we) scale_reg = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) predict_vertices(i_s_tuser, i_s_tdata);
        end
        o_errors      <= mismatches;
        o_outstanding <= expected_vertices.size();
    end

endmodule

// ===== test/bezier_outline_flattener_test.sv =====
module bezier_outline_flattener_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bof_pkg::*;

    localparam logic [COORD_W-1:0] C_MIN = 16'h8000;
    localparam logic [COORD_W-1:0] C_MAX = 16'h7fff;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [SCALE_W-1:0]   cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic [6*COORD_W-1:0] s_tdata   = '0;
    logic [CMD_W-1:0]     s_tuser   = '0;
    logic                 m_tready  = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [2*PT_W-1:0]    m_tdata;
    logic [0:0]           m_tuser;
    logic                 m_tlast;

    int  chk_errors;
    int  outstanding;
    int  src_idle_pct = 18;
    int  snk_idle_pct = 73;
    int  items_sent   = 0;
    bit  long_hold_done = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    bezier_outline_flattener dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    bezier_outline_flattener_check checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .i_m_tlast     (m_tlast),
        .o_errors      (chk_errors),
        .o_outstanding (outstanding)
    );

    // vertex sink; one long hold-off once the input stream is well underway
    initial begin
        forever begin
            @(posedge clk);
            if (!long_hold_done && items_sent >= 40) begin
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
                long_hold_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] cmd,
                            input logic [COORD_W-1:0] c1x, c1y, c2x, c2y, tx, ty);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ty, tx, c2y, c2x, c1y, c1x};
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // stop offering and let every expected vertex come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            case ($urandom_range(3))
                0: return C_MIN;
                1: return C_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        if (r < 35) return COORD_W'($urandom_range(1024)) - 16'd512;
        return COORD_W'($urandom);
    endfunction

    function automatic logic [CMD_W-1:0] pick_segment();
        int r;
        r = $urandom_range(99);
        if (r < 30) return CMD_LINE;
        if (r < 65) return CMD_QUAD;
        return CMD_CUBIC;
    endfunction

    // contours: mostly a move then a run of segments; sometimes no move
    task automatic random_outline(input int n_items);
        int done;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(99) < 85) begin
                send_cmd(CMD_MOVE, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord());
                done++;
            end
            repeat ($urandom_range(1, 8)) begin
                send_cmd(pick_segment(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord());
                done++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // unit scale; a curve before any move starts at the origin
        send_cmd(CMD_QUAD, 16'd1000, 16'd2000, C_MAX, C_MIN, 16'd3000, -16'sd500);
        send_cmd(CMD_LINE, C_MAX, C_MIN, C_MIN, C_MAX, -16'sd1234, 16'd5678);
        send_cmd(CMD_MOVE, 16'd77, -16'sd77, C_MAX, C_MAX, C_MIN, C_MAX);
        send_cmd(CMD_CUBIC, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN);
        send_cmd(CMD_QUAD, C_MIN, C_MAX, 16'd9, 16'd9, 16'd0, 16'd0);
        send_cmd(CMD_LINE, 16'd0, 16'd0, 16'd0, 16'd0, C_MAX, C_MAX);
        send_cmd(CMD_CUBIC, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        send_cmd(CMD_MOVE, 16'd0, 16'd0, 16'd0, 16'd0, -16'sd1, 16'd0);
        send_cmd(CMD_CUBIC, 16'd7, -16'sd7, -16'sd3, 16'd11, 16'd1, -16'sd1);
        send_cmd(CMD_QUAD, 16'hffff, 16'd1, C_MIN, C_MAX, 16'd2, -16'sd2);
        drain();

        // full-scale factor: saturation on large points
        write_scale('1);
        send_cmd(CMD_MOVE, 16'd0, 16'd0, 16'd0, 16'd0, C_MAX, C_MIN);
        send_cmd(CMD_LINE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd128, -16'sd128);
        send_cmd(CMD_LINE, 16'd0, 16'd0, 16'd0, 16'd0, 16'd129, -16'sd129);
        send_cmd(CMD_QUAD, -16'sd1, 16'd1, 16'd0, 16'd0, C_MIN, C_MAX);
        send_cmd(CMD_CUBIC, C_MAX, C_MIN, 16'd5, -16'sd5, -16'sd200, 16'd300);
        drain();

        write_scale('0);
        send_cmd(CMD_MOVE, 16'd0, 16'd0, 16'd0, 16'd0, C_MAX, C_MIN);
        send_cmd(CMD_CUBIC, C_MAX, C_MIN, 16'h5a5a, 16'ha5a5, C_MIN, C_MAX);
        drain();

        // smallest nonzero scale: everything rounds near zero
        write_scale(24'd1);
        send_cmd(CMD_QUAD, C_MAX, C_MIN, 16'd0, 16'd0, C_MIN, C_MAX);
        send_cmd(CMD_CUBIC, 16'd3, -16'sd3, -16'sd100, 16'd100, 16'd1, 16'd1);
        send_cmd(CMD_LINE, 16'd0, 16'd0, 16'd0, 16'd0, C_MIN, C_MIN);
        drain();

        write_scale(SCALE_W'($urandom_range(32768, 131072)));
        random_outline(120);
        drain();

        src_idle_pct = 73;
        snk_idle_pct = 18;
        write_scale(SCALE_W'($urandom));
        random_outline(120);
        drain();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_scale(SCALE_RESET);
        random_outline(100);
        drain();
        repeat (20) @(posedge clk);

        if (chk_errors == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
